@@ rtl/q4q8_pkg.sv @@
// q4q8_pkg: shared constants, opcode codes and controller/datapath interface
// structs for the q4/q8 weight reuse gemm unit
// no dependencies
package q4q8_pkg;

  localparam int MAX_COLUMNS = 16;
  localparam int COL_W       = 4;
  localparam int NUM_W       = 5;

  // input opcodes
  typedef enum logic [1:0] {
    OP_WEIGHT = 2'd0,
    OP_ACT    = 2'd1,
    OP_EOR    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // operand preparation select of the float unit
  typedef enum logic [2:0] {
    PREP_NONE   = 3'd0,
    PREP_CVT    = 3'd1,
    PREP_MUL_DX = 3'd2,
    PREP_MUL_DY = 3'd3,
    PREP_ADD    = 3'd4
  } prep_t;

  // controller to datapath commands
  typedef struct packed {
    logic  accept;
    prep_t prep;
    logic  norm;
    logic  round;
    logic  acc_wr;
    logic  emit_load;
    logic  acc_clear;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic col_ok;
    logic emit_last;
    logic out_free;
    logic n_zero;
  } dp_status_t;

endpackage

@@ rtl/q4q8_ctrl.sv @@
// q4q8_ctrl: sequencer of the q4/q8 weight reuse gemm unit
// steps the float fold and the end-of-row emission; depends on q4q8_pkg
module q4q8_ctrl import q4q8_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] opcode,
  input  logic [1:0] beat,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [13:0] {
    S_IDLE = 14'h0001,
    S_CVT  = 14'h0002,
    S_N1   = 14'h0004,
    S_R1   = 14'h0008,
    S_M1   = 14'h0010,
    S_N2   = 14'h0020,
    S_R2   = 14'h0040,
    S_M2   = 14'h0080,
    S_N3   = 14'h0100,
    S_R3   = 14'h0200,
    S_ADD  = 14'h0400,
    S_N4   = 14'h0800,
    S_R4   = 14'h1000,
    S_EMIT = 14'h2000
  } state_t;

  state_t state, state_next;
  logic   accept;
  op_t    op;

  assign op       = op_t'(opcode);
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.prep   = PREP_NONE;
    unique case (state)
      S_IDLE: begin
        cmd.accept = accept;
        if (accept && op == OP_ACT && beat == 2'd3 && status.col_ok) begin
          state_next = S_CVT;
        end else if (accept && op == OP_EOR) begin
          if (status.n_zero) begin
            cmd.acc_clear = 1'b1;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_CVT: begin
        cmd.prep   = PREP_CVT;
        state_next = S_N1;
      end
      S_N1: begin
        cmd.norm   = 1'b1;
        state_next = S_R1;
      end
      S_R1: begin
        cmd.round  = 1'b1;
        state_next = S_M1;
      end
      S_M1: begin
        cmd.prep   = PREP_MUL_DX;
        state_next = S_N2;
      end
      S_N2: begin
        cmd.norm   = 1'b1;
        state_next = S_R2;
      end
      S_R2: begin
        cmd.round  = 1'b1;
        state_next = S_M2;
      end
      S_M2: begin
        cmd.prep   = PREP_MUL_DY;
        state_next = S_N3;
      end
      S_N3: begin
        cmd.norm   = 1'b1;
        state_next = S_R3;
      end
      S_R3: begin
        cmd.round  = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.prep   = PREP_ADD;
        state_next = S_N4;
      end
      S_N4: begin
        cmd.norm   = 1'b1;
        state_next = S_R4;
      end
      S_R4: begin
        cmd.round  = 1'b1;
        cmd.acc_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_EMIT: begin
        cmd.emit_load = status.out_free;
        if (status.out_free && status.emit_last) begin
          cmd.acc_clear = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/q4q8_dp.sv @@
// q4q8_dp: datapath of the q4/q8 weight reuse gemm unit: weight store, lane
// dot product, fp32 convert/multiply/add unit, accumulators, output register
// depends on q4q8_pkg
module q4q8_dp import q4q8_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  input  logic [1:0]        opcode,
  input  logic [1:0]        beat,
  input  logic [COL_W-1:0]  column,
  input  logic [63:0]       data_bytes,
  input  logic [15:0]       scale_bits,
  input  logic              cfg_we,
  input  logic [NUM_W-1:0]  cfg_wdata,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [COL_W-1:0]  out_column,
  output logic [31:0]       sum_bits,
  output logic              last
);

  localparam logic [31:0] CANON_NAN = 32'h7FC00000;

  typedef struct packed {
    logic        s;
    logic [7:0]  e;
    logic [23:0] m;
    logic        nan;
    logic        inf;
    logic        zero;
  } unp_t;

  // fp16 to fp32, exact
  function automatic logic [31:0] half_to_float(input logic [15:0] h);
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [3:0]  pos;
    logic [9:0]  mn;
    logic [7:0]  e32;
    logic [31:0] r;
    ex  = h[14:10];
    man = h[9:0];
    pos = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) pos = 4'(i);
    end
    mn  = 10'(man << (4'd10 - pos));
    e32 = 8'd103 + {4'd0, pos};
    if (ex == 5'd0) begin
      r = (man == 10'd0) ? {h[15], 31'd0} : {h[15], e32, mn, 13'd0};
    end else if (ex == 5'd31) begin
      r = {h[15], 8'hFF, man, 13'd0};
    end else begin
      r = {h[15], 3'd0, ex, man, 13'd0} + {1'b0, 8'd112, 23'd0};
    end
    return r;
  endfunction

  function automatic unp_t unpack(input logic [31:0] b);
    unp_t u;
    u.s    = b[31];
    u.e    = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    u.m    = {(b[30:23] != 8'd0), b[22:0]};
    u.nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    u.inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    u.zero = (b[30:0] == 31'd0);
    return u;
  endfunction

  function automatic logic [5:0] lzc48(input logic [47:0] m);
    logic [5:0] lz;
    lz = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (m[i]) lz = 6'(47 - i);
    end
    return lz;
  endfunction

  function automatic logic [31:0] canon(input logic [31:0] b);
    return ((b[30:23] == 8'hFF) && (b[22:0] != 23'd0)) ? CANON_NAN : b;
  endfunction

  // state
  logic [7:0]         wq [16];
  logic [15:0]        wscale, ascale;
  logic [16:0]        partial;
  logic [31:0]        acc [MAX_COLUMNS];
  logic [NUM_W-1:0]   num_columns;
  logic [COL_W-1:0]   col_r;
  logic [31:0]        t_r;
  logic [COL_W-1:0]   idx;

  // float unit pipeline registers
  logic               p_sign, p_spec;
  logic [47:0]        p_m;
  logic signed [12:0] p_e;
  logic [31:0]        p_spec_bits;
  logic [5:0]         lz_r;

  op_t op;
  assign op = op_t'(opcode);

  // column count clamp and status
  logic [NUM_W-1:0] n_emit;
  assign n_emit           = (num_columns > NUM_W'(MAX_COLUMNS)) ? NUM_W'(MAX_COLUMNS)
                                                                : num_columns;
  assign status.col_ok    = ({1'b0, column} < num_columns);
  assign status.n_zero    = (n_emit == '0);
  assign status.emit_last = ({1'b0, idx} == n_emit - NUM_W'(1));
  assign status.out_free  = !out_valid || !out_stall;

  // eight lane dot product of one activation beat
  logic signed [16:0] lane_sum;
  always_comb begin
    logic [7:0]         q;
    logic signed [16:0] w;
    logic signed [16:0] a;
    lane_sum = '0;
    for (int i = 0; i < 8; i++) begin
      q = wq[{beat[0], 3'(i)}];
      w = 17'($signed({1'b0, (beat < 2'd2) ? q[3:0] : q[7:4]}) - 5'sd8);
      a = 17'($signed(data_bytes[8*i +: 8]));
      lane_sum = lane_sum + w * a;
    end
  end

  // item transfer: weights, scales, block partial
  always_ff @(posedge clk) begin
    if (rst) begin
      wscale  <= '0;
      ascale  <= '0;
      partial <= '0;
    end else if (cmd.accept) begin
      if (op == OP_WEIGHT && beat < 2'd2) begin
        if (beat == 2'd0) wscale <= scale_bits;
        for (int i = 0; i < 8; i++) begin
          wq[{beat[0], 3'(i)}] <= data_bytes[8*i +: 8];
        end
      end else if (op == OP_ACT && status.col_ok) begin
        if (beat == 2'd0) begin
          ascale  <= scale_bits;
          partial <= lane_sum;
        end else begin
          partial <= partial + lane_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && op == OP_ACT) col_r <= column;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      num_columns <= NUM_W'(1);
    end else if (cfg_we) begin
      num_columns <= cfg_wdata;
    end
  end

  // operand preparation
  logic [31:0] dxf, dyf, acc_rd;
  unp_t        ua, ub;
  assign dxf    = half_to_float(wscale);
  assign dyf    = half_to_float(ascale);
  assign acc_rd = acc[col_r];

  always_comb begin
    ua = unpack((cmd.prep == PREP_ADD) ? acc_rd : t_r);
    ub = unpack((cmd.prep == PREP_ADD) ? t_r :
                (cmd.prep == PREP_MUL_DX) ? dxf : dyf);
  end

  logic               n_sign, n_spec;
  logic [47:0]        n_m;
  logic signed [12:0] n_e;
  logic [31:0]        n_spec_bits;

  always_comb begin
    logic [17:0] mag;
    logic        big_a;
    logic [7:0]  eb, es, d;
    logic [23:0] mb, ms;
    logic        sb, ss, st;
    logic [26:0] sm, shd, small_v;
    logic [27:0] r28;
    n_sign      = p_sign;
    n_spec      = p_spec;
    n_m         = p_m;
    n_e         = p_e;
    n_spec_bits = p_spec_bits;
    mag         = partial[16] ? 18'(-$signed({partial[16], partial})) : {1'b0, partial};
    big_a       = (ua.e > ub.e) || ((ua.e == ub.e) && (ua.m >= ub.m));
    eb          = big_a ? ua.e : ub.e;
    es          = big_a ? ub.e : ua.e;
    mb          = big_a ? ua.m : ub.m;
    ms          = big_a ? ub.m : ua.m;
    sb          = big_a ? ua.s : ub.s;
    ss          = big_a ? ub.s : ua.s;
    d           = eb - es;
    sm          = {ms, 3'd0};
    if (d >= 8'd27) begin
      shd = '0;
      st  = |ms;
    end else begin
      shd = sm >> d;
      st  = |(sm & ~(27'h7FFFFFF << d));
    end
    small_v = {shd[26:1], shd[0] | st};
    r28     = (sb == ss) ? ({1'b0, mb, 3'd0} + {1'b0, small_v})
                         : ({1'b0, mb, 3'd0} - {1'b0, small_v});
    case (cmd.prep)
      PREP_CVT: begin
        n_sign = partial[16];
        n_spec = 1'b0;
        n_m    = {30'd0, mag};
        n_e    = '0;
      end
      PREP_MUL_DX, PREP_MUL_DY: begin
        n_sign      = ua.s ^ ub.s;
        n_m         = ua.m * ub.m;
        n_e         = $signed({5'd0, ua.e}) + $signed({5'd0, ub.e}) - 13'sd300;
        n_spec      = ua.nan || ub.nan || ua.inf || ub.inf;
        n_spec_bits = (ua.nan || ub.nan || (ua.inf && ub.zero) || (ua.zero && ub.inf))
                      ? CANON_NAN : {ua.s ^ ub.s, 8'hFF, 23'd0};
      end
      PREP_ADD: begin
        n_sign      = (r28 == '0) ? (ua.s & ub.s) : sb;
        n_m         = {20'd0, r28};
        n_e         = $signed({5'd0, eb}) - 13'sd153;
        n_spec      = ua.nan || ub.nan || ua.inf || ub.inf;
        n_spec_bits = (ua.nan || ub.nan || (ua.inf && ub.inf && (ua.s != ub.s)))
                      ? CANON_NAN : (ua.inf ? {ua.s, 8'hFF, 23'd0} : {ub.s, 8'hFF, 23'd0});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    p_sign      <= n_sign;
    p_spec      <= n_spec;
    p_m         <= n_m;
    p_e         <= n_e;
    p_spec_bits <= n_spec_bits;
    if (cmd.norm) lz_r <= lzc48(p_m);
  end

  // normalize and round to nearest even
  logic [31:0] rnd;
  always_comb begin
    logic [47:0]        mn, q;
    logic signed [12:0] be, extra, shf;
    logic [5:0]         sh;
    logic [7:0]         bem1;
    logic               guard, sticky, rup;
    logic [30:0]        packed_v;
    mn    = p_m << lz_r;
    be    = p_e + 13'sd174 - $signed({7'd0, lz_r});
    extra = (be < 13'sd1) ? (13'sd1 - be) : 13'sd0;
    shf   = 13'sd24 + extra;
    sh    = (shf > 13'sd63) ? 6'd63 : shf[5:0];
    bem1  = (be < 13'sd1) ? 8'd0 : be[7:0] - 8'd1;
    q     = mn >> sh;
    // guard bit lies above the mantissa once the shift passes its width
    guard = (sh > 6'd48) ? 1'b0 : mn[sh - 6'd1];
    sticky = |(mn & ((48'd1 << (sh - 6'd1)) - 48'd1));
    rup   = guard && (sticky || q[0]);
    packed_v = {bem1, 23'd0} + {7'd0, q[23:0]} + {30'd0, rup};
    if (p_spec) begin
      rnd = p_spec_bits;
    end else if (p_m == '0) begin
      rnd = {p_sign, 31'd0};
    end else if (be >= 13'sd255) begin
      rnd = {p_sign, 8'hFF, 23'd0};
    end else begin
      rnd = {p_sign, packed_v};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.round) t_r <= rnd;
  end

  // column accumulators
  always_ff @(posedge clk) begin
    if (rst || cmd.acc_clear) begin
      for (int i = 0; i < MAX_COLUMNS; i++) acc[i] <= '0;
    end else if (cmd.acc_wr) begin
      acc[col_r] <= canon(rnd);
    end
  end

  // emission index and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
      idx       <= status.emit_last ? '0 : idx + COL_W'(1);
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_column <= idx;
      sum_bits   <= acc[idx];
      last       <= status.emit_last;
    end
  end

endmodule

@@ rtl/q4_q8_gemm_weight_reuse_unit.sv @@
// q4_q8_gemm_weight_reuse_unit: top level of the q4/q8 weight reuse gemm unit
// depends on q4q8_pkg, q4q8_ctrl, q4q8_dp
//
// Usage. Load a 4-bit weight block as two weight beats (opcode 0, beat 0 with
// the fp16 scale, then beat 1). For each column below num_columns send four
// activation beats (opcode 1, beats 0..3, scale on beat 0). The block is reused
// for every column. An end-of-row item (opcode 2) emits one result per column,
// column 0 upward, with last on the final one, and clears the accumulators.
// num_columns is written through cfg_we/cfg_wdata while the block is idle.
// Weight beats and activation beats 0..2 are taken while in_stall is low and
// leave it low. Beat 3 starts the fp32 fold (convert, two multiplies, add, each
// a prepare, normalize and round step in the shared float unit), with in_stall
// high until it ends. End of row keeps in_stall high while results load into
// the output register; the next input is taken once the last one sits there.
// A stalled result holds in the output register until its transfer.
// Reset clears the accumulators to +0, the scales and partial to 0 and sets
// num_columns to 1; weight bytes are undefined until written.
module q4_q8_gemm_weight_reuse_unit import q4q8_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        opcode,
  input  logic [1:0]        beat,
  input  logic [COL_W-1:0]  column,
  input  logic [63:0]       data_bytes,
  input  logic [15:0]       scale_bits,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [COL_W-1:0]  out_column,
  output logic [31:0]       sum_bits,
  output logic              last,
  input  logic              cfg_we,
  input  logic [NUM_W-1:0]  cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  q4q8_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .beat     (beat),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  q4q8_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .opcode     (opcode),
    .beat       (beat),
    .column     (column),
    .data_bytes (data_bytes),
    .scale_bits (scale_bits),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_column (out_column),
    .sum_bits   (sum_bits),
    .last       (last)
  );

endmodule

@@ rtl/q4q8_checker.sv @@
// q4q8_checker: port level assertions of the q4/q8 weight reuse gemm unit
// depends on q4q8_pkg; bound to q4_q8_gemm_weight_reuse_unit
module q4q8_checker import q4q8_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [COL_W-1:0]  out_column,
  input logic [31:0]       sum_bits,
  input logic              last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_column) && $stable(sum_bits)
      && $stable(last))
    else $error("stalled result changed");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // input held off while a row run is still being emitted
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("input taken during emission");

  // the top column always closes a run
  a_top_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_column == 4'd15 |-> last)
    else $error("column 15 not last");

endmodule

bind q4_q8_gemm_weight_reuse_unit q4q8_checker u_chk (.*);
